/* rtl/core/ppr_pkg.sv */
package ppr_pkg;

   localparam int QTR_SIZE = 1024;

   // register indexes on the csr port
   localparam logic [1:0] REG_COUNT  = 2'd0;
   localparam logic [1:0] REG_CX     = 2'd1;
   localparam logic [1:0] REG_CY     = 2'd2;
   localparam logic [1:0] REG_RADIUS = 2'd3;

   // phase steps per 1/256 s tick, 16-bit turns scaled by 2^16
   localparam logic [22:0] ROT_STEP = 23'd1602106;
   localparam logic [22:0] WOB_STEP = 23'd5340354;

   typedef logic [14:0] sine_tbl_type [0:QTR_SIZE-1];
   typedef logic [63:0] div_list_type [0:5];

   localparam div_list_type TAYLOR_DIVS = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

   // quarter-wave sine, Q1.15, sampled at bin centers (horner series in Q30)
   function automatic sine_tbl_type build_sine();
      sine_tbl_type t;
      logic [63:0]  x;
      logic [63:0]  x2;
      logic [63:0]  h;
      logic [63:0]  s;
      logic [63:0]  e;
      for (int k = 0; k < QTR_SIZE; k++) begin
         x  = (64'(2 * k + 1) * 64'd3373259426) >> 12;
         x2 = (x * x) >> 30;
         h  = 64'd1 << 30;
         for (int j = 0; j < 6; j++) begin
            h = (64'd1 << 30) - (((x2 * h) >> 30) / TAYLOR_DIVS[j]);
         end
         s    = (x * h) >> 30;
         e    = (s * 64'd32767 + (64'd1 << 29)) >> 30;
         t[k] = e[14:0];
      end
      return t;
   endfunction

   localparam sine_tbl_type SINE_TBL = build_sine();

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_RUN  = 3'b100
   } seq_state_type;

endpackage

/* rtl/core/pulsing_particle_ring_generator_unit.sv */
// pulsing particle ring generator
// req channel: one beat per animation frame, req_tdata = frame_time (24 bits, 1/256 s units)
// then shake_level (9 bits, Q1.8 intensity, clamped at 1.0). rsp channel: one beat per
// particle, particle_count beats per frame (capped at MAX_PARTICLES), rsp_tlast on the
// final one. a zero count swallows the frame with no rsp beats.
// csr port: csr_wen/csr_index/csr_wdata write count, center x/y and base radius; write
// only while no frame is in flight.
// timing: a frame is accepted only in idle; a 17-step restoring divider then computes the
// angular spacing 65536/count, after which the sequencer issues one particle per cycle
// while the output is not stalled, into a seven-register pipeline (phase, sine lookup,
// radius terms, radius/brightness, partial products, rounding, output).
// reset clears the csr registers to 16 / 160 / 120 / 40, empties the pipeline and
// returns the sequencer to idle.
// when rsp_tready is low with a beat waiting, the whole pipeline and particle issue hold
// (the divider runs on); nothing is dropped or repeated, and a new frame may be taken
// while the previous frame's particles are still draining.
module pulsing_particle_ring_generator_unit
   import ppr_pkg::*;
#(
   parameter int MAX_PARTICLES = 64
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // frame_time[23:0], shake_level[32:24], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // pos_x[16:0], pos_y[33:17], brightness[41:34],
                                    // dot_size[44:42], zero pad
   output logic        rsp_tlast,
   input  logic        csr_wen,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int IW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;

   // ---------------- csr registers ----------------
   logic [6:0]  count_ff;
   logic [15:0] cx_ff;
   logic [15:0] cy_ff;
   logic [9:0]  radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 7'd16;
         cx_ff     <= 16'd160;
         cy_ff     <= 16'd120;
         radius_ff <= 10'd40;
      end else if (csr_wen) begin
         unique case (csr_index)
            REG_COUNT:  count_ff  <= csr_wdata[6:0];
            REG_CX:     cx_ff     <= csr_wdata;
            REG_CY:     cy_ff     <= csr_wdata;
            REG_RADIUS: radius_ff <= csr_wdata[9:0];
            default:    ;
         endcase
      end
   end

   // global advance: the output register is free or being drained
   logic adv;
   logic out_v_ff;
   assign adv = !out_v_ff || rsp_tready;

   // ---------------- frame sequencer ----------------
   seq_state_type state_ff, state_in;
   logic [6:0]  n_ff;
   logic [6:0]  n_lim;
   logic [23:0] ft_ff;
   logic [8:0]  inten_ff;
   logic [2:0]  dot_ff;
   logic [4:0]  dcnt_ff;
   logic [6:0]  rem_ff, rem_in;
   logic [16:0] quo_ff, quo_in;
   logic [6:0]  rem_sh;
   logic        rem_ge;
   logic [34:0] rot_lo_ff, rot_hi_ff, wob_lo_ff, wob_hi_ff;
   logic [31:0] rot_sum, wob_sum;
   logic [15:0] rot_ff, wob_ff;
   logic [16:0] base_ff, base_in;
   logic [6:0]  racc_ff, racc_in, racc_sum;
   logic        racc_carry;
   logic [IW-1:0] idx_ff;
   logic        seq_last;
   logic        req_acc;
   logic [8:0]  inten_lim;
   logic [9:0]  dot_sum;

   assign n_lim     = (count_ff > 7'(MAX_PARTICLES)) ? 7'(MAX_PARTICLES) : count_ff;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc   = req_tvalid && req_tready;
   assign inten_lim = (req_tdata[32:24] > 9'd256) ? 9'd256 : req_tdata[32:24];
   // round half up of 2*I/256
   assign dot_sum   = {inten_lim, 1'b0} + 10'd128;

   // restoring divide of 65536 by n, one quotient bit per cycle
   assign rem_sh = {rem_ff[5:0], (dcnt_ff == 5'd16)};
   assign rem_ge = (rem_sh >= n_ff);
   assign rem_in = rem_ge ? (rem_sh - n_ff) : rem_sh;
   assign quo_in = {quo_ff[15:0], rem_ge};

   // only bits 31..16 of frame_time * step are needed, so low 32 bits suffice
   assign rot_sum = rot_lo_ff[31:0] + {rot_hi_ff[19:0], 12'd0} + 32'h8000;
   assign wob_sum = wob_lo_ff[31:0] + {wob_hi_ff[19:0], 12'd0} + 32'h8000;

   // particle spacing: base += quo, with the remainder carried in racc
   assign racc_sum   = racc_ff + rem_ff;
   assign racc_carry = (racc_sum >= n_ff);
   assign racc_in    = racc_carry ? (racc_sum - n_ff) : racc_sum;
   assign base_in    = base_ff + quo_ff + 17'(racc_carry);
   assign seq_last   = (idx_ff == IW'(n_ff - 7'd1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_acc && n_lim != 7'd0) state_in = ST_DIV;
         ST_DIV:  if (dcnt_ff == 5'd0) state_in = ST_RUN;
         ST_RUN:  if (adv && seq_last) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         ft_ff    <= req_tdata[23:0];
         inten_ff <= inten_lim;
         dot_ff   <= 3'd2 + dot_sum[9:8];
         n_ff     <= n_lim;
         dcnt_ff  <= 5'd16;
         rem_ff   <= '0;
         quo_ff   <= '0;
      end
      if (state_ff == ST_DIV) begin
         rot_lo_ff <= 35'(ft_ff[11:0]) * 35'(ROT_STEP);
         rot_hi_ff <= 35'(ft_ff[23:12]) * 35'(ROT_STEP);
         wob_lo_ff <= 35'(ft_ff[11:0]) * 35'(WOB_STEP);
         wob_hi_ff <= 35'(ft_ff[23:12]) * 35'(WOB_STEP);
         rem_ff    <= rem_in;
         quo_ff    <= quo_in;
         dcnt_ff   <= dcnt_ff - 5'd1;
         if (dcnt_ff == 5'd0) begin
            rot_ff  <= rot_sum[31:16];
            wob_ff  <= wob_sum[31:16];
            base_ff <= '0;
            racc_ff <= '0;
            idx_ff  <= '0;
         end
      end
      if (state_ff == ST_RUN && adv) begin
         base_ff <= base_in;
         racc_ff <= racc_in;
         idx_ff  <= idx_ff + IW'(1);
      end
   end

   // ---------------- stage 1: phases ----------------
   logic        v1_ff;
   logic [15:0] ang_ff, cph_ff, wph_ff;
   logic [15:0] ang_in, wph_in;
   logic        last1_ff;
   logic [8:0]  i1_ff;
   logic [2:0]  dot1_ff;

   assign ang_in = base_ff[15:0] + rot_ff;
   assign wph_in = {base_ff[14:0], 1'b0} + base_ff[15:0] + wob_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= (state_ff == ST_RUN);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ang_ff   <= ang_in;
         cph_ff   <= ang_in + 16'h4000;
         wph_ff   <= wph_in;
         last1_ff <= seq_last;
         i1_ff    <= inten_ff;
         dot1_ff  <= dot_ff;
      end
   end

   // ---------------- stage 2: sine lookups ----------------
   logic        v2_ff, last2_ff;
   logic [8:0]  i2_ff;
   logic [2:0]  dot2_ff;
   logic [14:0] cmag2, smag2, wmag2;
   logic        cneg2, sneg2, wneg2;

   ppr_sine u_cos (.clock(clock), .en(adv), .phase(cph_ff), .mag_ff(cmag2), .neg_ff(cneg2));
   ppr_sine u_sin (.clock(clock), .en(adv), .phase(ang_ff), .mag_ff(smag2), .neg_ff(sneg2));
   ppr_sine u_wob (.clock(clock), .en(adv), .phase(wph_ff), .mag_ff(wmag2), .neg_ff(wneg2));

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         last2_ff <= last1_ff;
         i2_ff    <= i1_ff;
         dot2_ff  <= dot1_ff;
      end
   end

   // ---------------- stage 3: radius and brightness products ----------------
   logic        v3_ff, last3_ff;
   logic [2:0]  dot3_ff;
   logic [18:0] rterm, w5;
   logic [17:0] bterm;
   logic [27:0] m1_ff;
   logic [26:0] m2_ff;
   logic [14:0] cmag3_ff, smag3_ff;
   logic        cneg3_ff, sneg3_ff;

   assign w5    = {2'd0, wmag2, 2'd0} + {4'd0, wmag2};
   assign rterm = wneg2 ? (19'd196608 - w5) : (19'd196608 + w5);
   assign bterm = wneg2 ? (18'd131072 - {3'd0, wmag2}) : (18'd131072 + {3'd0, wmag2});

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_ff    <= i2_ff * rterm;
         m2_ff    <= i2_ff * bterm;
         cmag3_ff <= cmag2;
         smag3_ff <= smag2;
         cneg3_ff <= cneg2;
         sneg3_ff <= sneg2;
         last3_ff <= last2_ff;
         dot3_ff  <= dot2_ff;
      end
   end

   // ---------------- stage 4: radius sum, brightness rounding ----------------
   logic        v4_ff, last4_ff;
   logic [2:0]  dot4_ff;
   logic [33:0] r_ff;
   logic [7:0]  lvl4_ff;
   logic [32:0] bprod;
   logic [9:0]  lvl_raw;
   logic [14:0] cmag4_ff, smag4_ff;
   logic        cneg4_ff, sneg4_ff;

   assign bprod   = 33'(m2_ff) * 33'd51 + 33'h400000;
   assign lvl_raw = bprod[32:23];

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r_ff     <= {1'b0, radius_ff, 23'd0} + {6'd0, m1_ff};
         lvl4_ff  <= (lvl_raw > 10'd255) ? 8'd255 : lvl_raw[7:0];
         cmag4_ff <= cmag3_ff;
         smag4_ff <= smag3_ff;
         cneg4_ff <= cneg3_ff;
         sneg4_ff <= sneg3_ff;
         last4_ff <= last3_ff;
         dot4_ff  <= dot3_ff;
      end
   end

   // ---------------- stage 5: partial products trig * r ----------------
   logic        v5_ff, last5_ff, cneg5_ff, sneg5_ff;
   logic [2:0]  dot5_ff;
   logic [7:0]  lvl5_ff;
   logic [31:0] xl_ff, xh_ff, yl_ff, yh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (adv) begin
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         xl_ff    <= cmag4_ff * r_ff[16:0];
         xh_ff    <= cmag4_ff * r_ff[33:17];
         yl_ff    <= smag4_ff * r_ff[16:0];
         yh_ff    <= smag4_ff * r_ff[33:17];
         cneg5_ff <= cneg4_ff;
         sneg5_ff <= sneg4_ff;
         lvl5_ff  <= lvl4_ff;
         last5_ff <= last4_ff;
         dot5_ff  <= dot4_ff;
      end
   end

   // ---------------- stage 6: round magnitude half away from zero ----------------
   logic        v6_ff, last6_ff, cneg6_ff, sneg6_ff;
   logic [2:0]  dot6_ff;
   logic [7:0]  lvl6_ff;
   logic [11:0] qx_ff, qy_ff;
   logic [49:0] xsum, ysum;

   assign xsum = {xh_ff, 17'd0} + {18'd0, xl_ff} + (50'd1 << 37);
   assign ysum = {yh_ff, 17'd0} + {18'd0, yl_ff} + (50'd1 << 37);

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (adv) begin
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         qx_ff    <= xsum[49:38];
         qy_ff    <= ysum[49:38];
         cneg6_ff <= cneg5_ff;
         sneg6_ff <= sneg5_ff;
         lvl6_ff  <= lvl5_ff;
         last6_ff <= last5_ff;
         dot6_ff  <= dot5_ff;
      end
   end

   // ---------------- stage 7: apply sign, add center, output register ----------------
   logic [16:0] ox, oy, px_in, py_in;
   logic [16:0] px_ff, py_ff;
   logic [7:0]  lvl_ff;
   logic [2:0]  dot_out_ff;
   logic        last_ff;

   assign ox    = cneg6_ff ? (17'd0 - {5'd0, qx_ff}) : {5'd0, qx_ff};
   assign oy    = sneg6_ff ? (17'd0 - {5'd0, qy_ff}) : {5'd0, qy_ff};
   assign px_in = {cx_ff[15], cx_ff} + ox;
   assign py_in = {cy_ff[15], cy_ff} + oy;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         px_ff      <= px_in;
         py_ff      <= py_in;
         lvl_ff     <= lvl6_ff;
         dot_out_ff <= dot6_ff;
         last_ff    <= last6_ff;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {3'd0, dot_out_ff, lvl_ff, py_ff, px_ff};
   assign rsp_tlast  = last_ff;

`ifndef SYNTHESIS
   // a frame with particles always starts the divider
   a_frame_div: assert property (@(posedge clock) disable iff (reset)
      (req_acc && n_lim != 7'd0) |=> (state_ff == ST_DIV))
      else $error("frame accepted without starting divide");

   // base angle stays below one turn while particles are issued
   a_base_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> !base_ff[16])
      else $error("base phase out of range");

   // remainder accumulator stays below the count
   a_racc_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (racc_ff < n_ff))
      else $error("spacing remainder out of range");

   // the sequencer issues nothing while the pipeline is stalled
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && !adv) |=> $stable(idx_ff))
      else $error("particle index moved during stall");
`endif

endmodule

/* rtl/core/ppr_sine.sv */
module ppr_sine
   import ppr_pkg::*;
(
   input  logic        clock,
   input  logic        en,
   input  logic [15:0] phase,
   output logic [14:0] mag_ff,
   output logic        neg_ff
);

   logic [9:0] idx;

   // odd quadrants read the table mirrored
   assign idx = phase[14] ? ~phase[13:4] : phase[13:4];

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff <= SINE_TBL[idx];
         neg_ff <= phase[15];
      end
   end

endmodule

/* bench/tb_pulsing_particle_ring_generator_unit.sv */
`timescale 1ns / 100ps

module tb_pulsing_particle_ring_generator_unit;
   import ppr_pkg::*;

   localparam int NUM_PARTICLES = 64;
   localparam int CYCLE_LIMIT   = 3000000;
   localparam int DRAIN_CYCLES  = 120;   // frame front end plus pipeline depth, with margin

   // one expected particle beat
   typedef struct {
      logic [16:0] pos_x;
      logic [16:0] pos_y;
      logic [7:0]  brightness;
      logic [2:0]  dot_size;
      logic        last_particle;
   } particle_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;   // frame_time[23:0], shake_level[32:24], zero pad
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;   // pos_x[16:0], pos_y[33:17], brightness[41:34], dot_size[44:42]
   logic        rsp_tlast;
   logic        csr_wen;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   pulsing_particle_ring_generator_unit #(.MAX_PARTICLES(NUM_PARTICLES)) dut (.*);

   // own copy of the quarter-wave sine and the register file
   logic [14:0]  quarter_sine [0:1023];
   logic [6:0]   ring_count;
   logic [15:0]  ring_cx;
   logic [15:0]  ring_cy;
   logic [9:0]   ring_radius;

   particle_type pending_particles [$];
   int           error_count;
   int           frame_count;
   int           beat_count;
   int           cycle_count;
   bit           no_idle;        // stretches with no gaps on either side
   int           stall_request;  // long receiver hold-off, picked up by the ready process
   int           stall_left;

   // clock and run limit
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t timeout with %0d particles outstanding", $time,
                  pending_particles.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // quarter-wave table from a horner sine series in Q30
   function automatic void build_quarter_sine();
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] h;
      logic [63:0] s;
      logic [63:0] divs [0:5];
      divs = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
      for (int k = 0; k < 1024; k++) begin
         x  = (64'(2 * k + 1) * 64'd3373259426) / 64'd4096;
         x2 = (x * x) >> 30;
         h  = 64'd1 << 30;
         for (int j = 0; j < 6; j++)
            h = (64'd1 << 30) - ((x2 * h) >> 30) / divs[j];
         s = (x * h) >> 30;
         quarter_sine[k] = 15'((s * 64'd32767 + (64'd1 << 29)) >> 30);
      end
   endfunction

   function automatic longint sine_of_turn(logic [15:0] phase);
      logic [9:0] idx;
      longint     v;
      idx = phase[13:4];
      v = phase[14] ? longint'(quarter_sine[1023 - idx]) : longint'(quarter_sine[idx]);
      return phase[15] ? -v : v;
   endfunction

   // trig (Q1.15) times radius (Q23), rounded half away from zero to pixels
   function automatic longint pixel_offset(longint trig, longint radius_q23);
      longint mag;
      longint q;
      mag = (trig < 0) ? -trig : trig;
      q = (mag * radius_q23 + (longint'(1) << 37)) >>> 38;
      return (trig < 0) ? -q : q;
   endfunction

   // work out every particle of one frame and queue them
   task automatic predict_ring(logic [23:0] frame_time, logic [8:0] shake_level);
      longint      n;
      longint      inten;
      logic [15:0] rot;
      logic [15:0] wob_t;
      logic [15:0] base;
      logic [15:0] ang;
      logic [15:0] wph;
      longint      wob;
      longint      rad;
      longint      lvl;
      longint      px;
      longint      py;
      particle_type p;
      n = (ring_count > NUM_PARTICLES) ? NUM_PARTICLES : ring_count;
      inten = (shake_level > 256) ? 256 : shake_level;
      rot   = 16'((longint'(frame_time) * 1602106 + 32768) >> 16);
      wob_t = 16'((longint'(frame_time) * 5340354 + 32768) >> 16);
      for (longint i = 0; i < n; i++) begin
         base = 16'((i * 65536) / n);
         ang  = base + rot;
         wph  = 16'(3 * base) + wob_t;
         wob  = sine_of_turn(wph);
         rad  = (longint'(ring_radius) << 23) + inten * (196608 + 5 * wob);
         px   = longint'($signed(ring_cx)) + pixel_offset(sine_of_turn(ang + 16'd16384), rad);
         py   = longint'($signed(ring_cy)) + pixel_offset(sine_of_turn(ang), rad);
         lvl  = (inten * (131072 + wob) * 51 + (longint'(1) << 22)) >>> 23;
         p.pos_x         = px[16:0];
         p.pos_y         = py[16:0];
         p.brightness    = (lvl > 255) ? 8'd255 : lvl[7:0];
         p.dot_size      = 3'(2 + ((2 * inten + 128) >> 8));
         p.last_particle = (i == n - 1);
         pending_particles.push_back(p);
      end
   endtask

   function automatic int random_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_idle || roll < 45) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 50);
   endfunction

   // offer one frame beat, hold it until taken; valid stays high into a back-to-back beat
   task automatic send_frame(logic [23:0] frame_time, logic [8:0] shake_level);
      int gap;
      gap = random_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, shake_level, frame_time};
      do @(posedge clock); while (!req_tready);
      predict_ring(frame_time, shake_level);
      frame_count++;
   endtask

   // drop valid at the edge where the last beat was taken
   task automatic release_req();
      req_tvalid <= 1'b0;
   endtask

   // all particles in and the front end quiet again
   task automatic wait_idle();
      release_req();
      while (pending_particles.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // csr writes only while idle; prediction registers follow the same write
   task automatic write_ring(logic [6:0] count, logic [15:0] cx, logic [15:0] cy,
                             logic [9:0] radius);
      wait_idle();
      @(posedge clock);
      csr_wen <= 1'b1; csr_index <= REG_COUNT;  csr_wdata <= 16'(count);
      @(posedge clock);
      csr_index <= REG_CX;     csr_wdata <= cx;
      @(posedge clock);
      csr_index <= REG_CY;     csr_wdata <= cy;
      @(posedge clock);
      csr_index <= REG_RADIUS; csr_wdata <= 16'(radius);
      @(posedge clock);
      csr_wen <= 1'b0;
      ring_count = count; ring_cx = cx; ring_cy = cy; ring_radius = radius;
   endtask

   // receiver: short random stalls, occasional long ones, plus the requested hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_request > 0) begin
         stall_left    = stall_request;
         stall_request = 0;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (no_idle) begin
         rsp_tready <= 1'b1;
      end else begin
         stall_left = random_gap() / 2;
         rsp_tready <= (stall_left == 0);
      end
   end

   // particle checker: each beat against the oldest expectation
   always @(posedge clock) begin
      particle_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         beat_count++;
         if (pending_particles.size() == 0) begin
            $display("%0t unexpected particle beat %h", $time, rsp_tdata);
            error_count++;
         end else begin
            want = pending_particles.pop_front();
            if (rsp_tdata[16:0] !== want.pos_x) begin
               $display("%0t pos_x expected %0d got %0d", $time,
                        $signed(want.pos_x), $signed(rsp_tdata[16:0]));
               error_count++;
            end
            if (rsp_tdata[33:17] !== want.pos_y) begin
               $display("%0t pos_y expected %0d got %0d", $time,
                        $signed(want.pos_y), $signed(rsp_tdata[33:17]));
               error_count++;
            end
            if (rsp_tdata[41:34] !== want.brightness) begin
               $display("%0t brightness expected %0d got %0d", $time,
                        want.brightness, rsp_tdata[41:34]);
               error_count++;
            end
            if (rsp_tdata[44:42] !== want.dot_size) begin
               $display("%0t dot_size expected %0d got %0d", $time,
                        want.dot_size, rsp_tdata[44:42]);
               error_count++;
            end
            if (rsp_tlast !== want.last_particle) begin
               $display("%0t tlast expected %0b got %0b", $time,
                        want.last_particle, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   // reset values, field extremes, intensity clamp
   task automatic test_default_ring();
      send_frame(24'd0, 9'd0);
      send_frame(24'hFFFFFF, 9'd256);
      send_frame(24'h000100, 9'd511);
      send_frame(24'h800000, 9'd257);
      send_frame(24'h555555, 9'd128);
      send_frame(24'hAAAAAA, 9'd127);
      send_frame(24'h000001, 9'd1);
   endtask

   // register extremes, a single particle, full capacity, zero and oversized counts
   task automatic test_register_extremes();
      write_ring(7'd1, 16'h8000, 16'h7FFF, 10'd1023);
      send_frame(24'h123456, 9'd256);
      send_frame(24'hFEDCBA, 9'd0);
      write_ring(7'd64, 16'h7FFF, 16'h8000, 10'd0);
      send_frame(24'h00FFFF, 9'd511);
      send_frame(24'hFF0000, 9'd64);
      write_ring(7'd0, 16'd0, 16'd0, 10'd512);
      send_frame(24'h3C3C3C, 9'd200);
      send_frame(24'hC3C3C3, 9'd300);
      write_ring(7'd127, 16'hFFFF, 16'h0001, 10'd1023);
      send_frame(24'h0F0F0F, 9'd256);
      write_ring(7'd3, 16'd0, 16'd0, 10'd1023);
      send_frame(24'hFFFFFF, 9'd511);
      send_frame(24'd0, 9'd255);
   endtask

   // random frames under a series of random settings, mostly small rings
   task automatic test_random_frames();
      int         roll;
      logic [6:0] count;
      for (int phase = 0; phase < 20; phase++) begin
         roll = $urandom_range(0, 99);
         if (roll < 8)       count = 7'd0;
         else if (roll < 16) count = 7'($urandom_range(64, 127));
         else                count = 7'($urandom_range(1, 12));
         write_ring(count, 16'($urandom), 16'($urandom), 10'($urandom));
         no_idle = (phase % 5 == 4);
         for (int k = 0; k < 10; k++)
            send_frame(24'($urandom),
                       ($urandom_range(0, 3) == 0) ? 9'($urandom) : 9'($urandom_range(0, 256)));
         no_idle = 1'b0;
      end
   endtask

   // receiver holds off while full rings keep coming, so the input must stall
   task automatic test_backpressure();
      write_ring(7'd64, 16'd160, 16'd120, 10'd40);
      no_idle = 1'b1;
      stall_request = 400;
      for (int k = 0; k < 6; k++)
         send_frame(24'($urandom), 9'($urandom));
      no_idle = 1'b0;
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      csr_wen    = 1'b0;
      csr_index  = REG_COUNT;
      csr_wdata  = '0;
      error_count = 0; frame_count = 0; beat_count = 0; cycle_count = 0;
      no_idle = 1'b0; stall_request = 0; stall_left = 0;
      ring_count = 7'd16; ring_cx = 16'd160; ring_cy = 16'd120; ring_radius = 10'd40;
      build_quarter_sine();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_default_ring();
      test_register_extremes();
      test_backpressure();
      test_random_frames();
      wait_idle();

      $display("covered %0d frames and %0d particle beats under zero, single, full and",
               frame_count, beat_count);
      $display("oversized ring counts, extreme centers and radii, and receiver hold-off");
      if (error_count == 0 && pending_particles.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
